>>> rtl/core/pfn_pkg.sv
// ============================================================================
// pfn_pkg: shared types and constants for the 2D Perlin fBm noise unit
// Fixed-point constants, register reset values, item kinds, sequencer steps.
// ============================================================================
`default_nettype none

package pfn_pkg;

  // Lattice tables
  localparam int TABLE_SIZE = 256;

  // Octave limit default
  localparam int DEFAULT_MAX_OCTAVES = 16;

  // Register reset values
  localparam logic [23:0] RST_BASE_FREQ   = 24'd65536;
  localparam logic [23:0] RST_LACUNARITY  = 24'd131072;
  localparam logic [23:0] RST_PERSISTENCE = 24'd32768;
  localparam logic [23:0] RST_BASE_AMP    = 24'd65536;
  localparam logic [4:0]  RST_OCT_COUNT   = 5'd4;
  localparam logic [3:0]  RST_CONTRAST    = 4'd1;
  localparam logic [23:0] RST_NOISE_SCALE = 24'd65536;

  // Q.16 fixed-point constants
  localparam int QUOT_LIM = 262144;  // 4.0

  // Input item kinds
  typedef enum logic [1:0] {
    KIND_PERM = 2'd0,
    KIND_GRAD = 2'd1,
    KIND_EVAL = 2'd2
  } kind_e;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_BASE_FREQ   = 3'd0,
    REG_LACUNARITY  = 3'd1,
    REG_PERSISTENCE = 3'd2,
    REG_BASE_AMP    = 3'd3,
    REG_OCT_COUNT   = 3'd4,
    REG_CONTRAST    = 3'd5,
    REG_NOISE_SCALE = 3'd6
  } reg_e;

  // Sequencer steps; the octave steps from ST_SX to ST_FRQ run in order
  typedef enum logic [5:0] {
    ST_IDLE,
    ST_SX, ST_SY,
    ST_FX1, ST_FX2, ST_FX3, ST_FX4,
    ST_FY1, ST_FY2, ST_FY3, ST_FY4,
    ST_D00A, ST_D00B, ST_D10A, ST_D10B,
    ST_D01A, ST_D01B, ST_D11A, ST_D11B,
    ST_L0, ST_L1, ST_L2, ST_L3,
    ST_N, ST_TM, ST_AMP, ST_FRQ,
    ST_NXT, ST_CHK,
    ST_DINIT, ST_DIV, ST_DEND,
    ST_PMUL, ST_PCAP,
    ST_SMUL, ST_SCAP,
    ST_FIN
  } step_e;

  // Controller to datapath commands
  typedef struct packed {
    step_e step;
    logic  err;
    logic  load_out;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic amp_zero;
  } status_t;

endpackage

`default_nettype wire

>>> rtl/core/pfn_ram.sv
// ============================================================================
// pfn_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ============================================================================
`default_nettype none

module pfn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

>>> rtl/core/pfn_ctrl.sv
// ============================================================================
// pfn_ctrl: sequencer for the noise unit
// Steps the datapath through octaves, division, power and scaling.
// ============================================================================
`default_nettype none

module pfn_ctrl #(
  parameter int CNT_W = 5,
  parameter int DIV_W = 51
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire pfn_pkg::kind_e    in_kind_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  input  wire logic [CNT_W-1:0]  eff_count_i,
  input  wire logic [3:0]        contrast_i,
  input  wire pfn_pkg::status_t  status_i,
  output pfn_pkg::cmd_t          cmd_o
);

  localparam int DC_W = (DIV_W > 1) ? $clog2(DIV_W) : 1;

  pfn_pkg::step_e   state_q, state_d;
  logic [CNT_W-1:0] oct_q, oct_d;
  logic [DC_W-1:0]  div_q, div_d;
  logic [3:0]       pow_q, pow_d;
  logic             err_q, err_d;
  logic             out_valid_q, out_valid_d;
  logic             start;
  logic             can_load;

  assign start    = (state_q == pfn_pkg::ST_IDLE) && in_valid_i
                    && (in_kind_i == pfn_pkg::KIND_EVAL);
  assign can_load = !out_valid_q || out_ready_i;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pfn_pkg::ST_IDLE: begin
        if (start) begin
          state_d = (eff_count_i == '0) ? pfn_pkg::ST_FIN : pfn_pkg::ST_SX;
        end
      end
      pfn_pkg::ST_SX, pfn_pkg::ST_SY, pfn_pkg::ST_FX1, pfn_pkg::ST_FX2,
      pfn_pkg::ST_FX3, pfn_pkg::ST_FX4, pfn_pkg::ST_FY1, pfn_pkg::ST_FY2,
      pfn_pkg::ST_FY3, pfn_pkg::ST_FY4, pfn_pkg::ST_D00A, pfn_pkg::ST_D00B,
      pfn_pkg::ST_D10A, pfn_pkg::ST_D10B, pfn_pkg::ST_D01A, pfn_pkg::ST_D01B,
      pfn_pkg::ST_D11A, pfn_pkg::ST_D11B, pfn_pkg::ST_L0, pfn_pkg::ST_L1,
      pfn_pkg::ST_L2, pfn_pkg::ST_L3, pfn_pkg::ST_N, pfn_pkg::ST_TM,
      pfn_pkg::ST_AMP, pfn_pkg::ST_FRQ: begin
        state_d = pfn_pkg::step_e'(state_q + 6'd1);
      end
      pfn_pkg::ST_NXT: begin
        state_d = (CNT_W'(oct_q + 1'b1) == eff_count_i) ? pfn_pkg::ST_CHK
                                                         : pfn_pkg::ST_SX;
      end
      pfn_pkg::ST_CHK: begin
        state_d = status_i.amp_zero ? pfn_pkg::ST_FIN : pfn_pkg::ST_DINIT;
      end
      pfn_pkg::ST_DINIT: state_d = pfn_pkg::ST_DIV;
      pfn_pkg::ST_DIV: begin
        if (div_q == DC_W'(DIV_W - 1)) begin
          state_d = pfn_pkg::ST_DEND;
        end
      end
      pfn_pkg::ST_DEND: begin
        state_d = (contrast_i == 4'd0) ? pfn_pkg::ST_SMUL : pfn_pkg::ST_PMUL;
      end
      pfn_pkg::ST_PMUL: state_d = pfn_pkg::ST_PCAP;
      pfn_pkg::ST_PCAP: begin
        state_d = (4'(pow_q + 1'b1) == contrast_i) ? pfn_pkg::ST_SMUL
                                                    : pfn_pkg::ST_PMUL;
      end
      pfn_pkg::ST_SMUL: state_d = pfn_pkg::ST_SCAP;
      pfn_pkg::ST_SCAP: state_d = pfn_pkg::ST_FIN;
      pfn_pkg::ST_FIN: begin
        if (can_load) begin
          state_d = pfn_pkg::ST_IDLE;
        end
      end
      default: state_d = pfn_pkg::ST_IDLE;
    endcase
  end

  // Counters, error flag and output valid
  always_comb begin
    oct_d       = oct_q;
    div_d       = div_q;
    pow_d       = pow_q;
    err_d       = err_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      pfn_pkg::ST_IDLE: begin
        if (start) begin
          oct_d = '0;
          err_d = (eff_count_i == '0);
        end
      end
      pfn_pkg::ST_NXT:   oct_d = CNT_W'(oct_q + 1'b1);
      pfn_pkg::ST_CHK:   err_d = status_i.amp_zero;
      pfn_pkg::ST_DINIT: div_d = '0;
      pfn_pkg::ST_DIV:   div_d = DC_W'(div_q + 1'b1);
      pfn_pkg::ST_DEND:  pow_d = '0;
      pfn_pkg::ST_PCAP:  pow_d = 4'(pow_q + 1'b1);
      pfn_pkg::ST_FIN: begin
        if (can_load) begin
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pfn_pkg::ST_IDLE;
      oct_q       <= '0;
      div_q       <= '0;
      pow_q       <= '0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      oct_q       <= oct_d;
      div_q       <= div_d;
      pow_q       <= pow_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Outputs
  always_comb begin
    in_ready_o     = (state_q == pfn_pkg::ST_IDLE);
    out_valid_o    = out_valid_q;
    cmd_o.step     = state_q;
    cmd_o.err      = err_q;
    cmd_o.load_out = (state_q == pfn_pkg::ST_FIN) && can_load;
  end

endmodule

`default_nettype wire

>>> rtl/core/pfn_dp.sv
// ============================================================================
// pfn_dp: datapath of the noise unit
// Tables, one shared signed multiplier, restoring divider and result registers.
// ============================================================================
`default_nettype none

module pfn_dp #(
  parameter int AS_W  = 29,
  parameter int TOT_W = 35,
  parameter int DIV_W = 51
) (
  input  wire logic               clk_i,
  input  wire logic               in_fire_i,
  input  wire pfn_pkg::kind_e     in_kind_i,
  input  wire logic [7:0]         table_index_i,
  input  wire logic [7:0]         perm_value_i,
  input  wire logic [15:0]        grad_x_i,
  input  wire logic [15:0]        grad_y_i,
  input  wire logic [31:0]        coord_x_i,
  input  wire logic [31:0]        coord_y_i,
  input  wire logic [23:0]        base_freq_i,
  input  wire logic [23:0]        lacunarity_i,
  input  wire logic [23:0]        persistence_i,
  input  wire logic [23:0]        base_amp_i,
  input  wire logic [23:0]        noise_scale_i,
  input  wire pfn_pkg::cmd_t      cmd_i,
  output pfn_pkg::status_t        status_o,
  output logic [31:0]             noise_value_o,
  output logic                    saturated_o,
  output logic                    error_o
);

  localparam logic signed [50:0] POW_HI = 51'sd274877906944;
  localparam logic signed [50:0] POW_LO = -51'sd274877906944;
  localparam logic signed [50:0] I32_HI = 51'sd2147483647;
  localparam logic signed [50:0] I32_LO = -51'sd2147483648;

  // 6t - 15.0 for the fade polynomial
  function automatic logic signed [22:0] fade_lin(input logic [15:0] t);
    logic [21:0] six_t;
    six_t = {4'b0, t, 2'b0} + {5'b0, t, 1'b0};
    return $signed({1'b0, six_t}) - 23'sd983040;
  endfunction

  // Clip a non-negative Q.16 value to the 24-bit register range
  function automatic logic [23:0] sat24(input logic signed [50:0] v);
    return (|v[50:24]) ? 24'hFFFFFF : v[23:0];
  endfunction

  // Point and per-octave state
  logic [31:0]             cx_q, cy_q;
  logic [23:0]             freq_q, amp_q;
  logic [7:0]              x0_q, y0_q, px0_q, px1_q;
  logic [7:0]              h00_q, h10_q, h01_q, h11_q;
  logic [15:0]             fx_q, fy_q, t3_q;
  logic [16:0]             u_q, v_q;
  logic [31:0]             g00_q, g10_q, g01_q, g11_q;
  logic signed [33:0]      dacc_q;
  logic signed [20:0]      d00_q, d10_q, d01_q, d11_q;
  logic signed [21:0]      l0_q, l1_q, noise_q;
  logic signed [TOT_W-1:0] total_q;
  logic [AS_W-1:0]         asum_q;
  // Divider, power and result
  logic [DIV_W-1:0]        num_q;
  logic [AS_W-1:0]         rem_q;
  logic                    neg_q;
  logic signed [19:0]      quot_q;
  logic signed [39:0]      acc_q;
  logic                    sat_q;
  logic [31:0]             res_q;
  logic [31:0]             out_value_q;
  logic                    out_sat_q, out_err_q;

  // Shared multiplier
  logic signed [40:0]      mul_a;
  logic signed [25:0]      mul_b;
  logic signed [66:0]      mul_q;
  logic signed [50:0]      p16;
  logic signed [34:0]      dsum;
  logic signed [20:0]      dot_new;
  logic signed [22:0]      fade_in;
  logic signed [17:0]      fxm, fym;

  // Table ports
  logic [7:0]              perm_raddr, perm_rd;
  logic [7:0]              grad_raddr;
  logic [31:0]             grad_rd;

  // Divider step
  logic [AS_W:0]           rem_sh;
  logic                    rem_ge;
  logic [TOT_W-1:0]        tot_abs;
  logic [DIV_W-1:0]        quot_mag;

  assign p16     = mul_q[66:16];
  assign dsum    = {dacc_q[33], dacc_q} + {mul_q[33], mul_q[33:0]};
  assign dot_new = dsum[34:14];
  assign fade_in = p16[22:0] + 23'sd655360;
  assign fxm     = $signed({2'b0, fx_q}) - 18'sd65536;
  assign fym     = $signed({2'b0, fy_q}) - 18'sd65536;
  assign rem_sh  = {rem_q, num_q[DIV_W-1]};
  assign rem_ge  = (rem_sh >= {1'b0, asum_q});
  assign tot_abs = total_q[TOT_W-1] ? TOT_W'(-total_q) : total_q;
  assign quot_mag = num_q;

  assign status_o.amp_zero = (asum_q == '0);

  // Tables
  pfn_ram #(.WIDTH(8), .DEPTH(pfn_pkg::TABLE_SIZE)) u_perm_ram (
    .clk_i   (clk_i),
    .we_i    (in_fire_i && (in_kind_i == pfn_pkg::KIND_PERM)),
    .waddr_i (table_index_i),
    .wdata_i (perm_value_i),
    .raddr_i (perm_raddr),
    .rdata_o (perm_rd)
  );

  pfn_ram #(.WIDTH(32), .DEPTH(pfn_pkg::TABLE_SIZE)) u_grad_ram (
    .clk_i   (clk_i),
    .we_i    (in_fire_i && (in_kind_i == pfn_pkg::KIND_GRAD)),
    .waddr_i (table_index_i),
    .wdata_i ({grad_y_i, grad_x_i}),
    .raddr_i (grad_raddr),
    .rdata_o (grad_rd)
  );

  // Table read addresses: corners hashed as perm[perm[x] + y]
  always_comb begin
    perm_raddr = '0;
    grad_raddr = '0;
    case (cmd_i.step)
      pfn_pkg::ST_FX1:  perm_raddr = x0_q;
      pfn_pkg::ST_FX2:  perm_raddr = 8'(x0_q + 8'd1);
      pfn_pkg::ST_FX3:  perm_raddr = 8'(px0_q + y0_q);
      pfn_pkg::ST_FX4:  perm_raddr = 8'(px1_q + y0_q);
      pfn_pkg::ST_FY1:  perm_raddr = 8'(px0_q + y0_q + 8'd1);
      pfn_pkg::ST_FY2:  perm_raddr = 8'(px1_q + y0_q + 8'd1);
      pfn_pkg::ST_FY3:  grad_raddr = h00_q;
      pfn_pkg::ST_FY4:  grad_raddr = h10_q;
      pfn_pkg::ST_D00A: grad_raddr = h01_q;
      pfn_pkg::ST_D00B: grad_raddr = h11_q;
      default: ;
    endcase
  end

  // Multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.step)
      pfn_pkg::ST_SX:   begin mul_a = 41'($signed(cx_q)); mul_b = $signed({2'b0, freq_q}); end
      pfn_pkg::ST_SY:   begin mul_a = 41'($signed(cy_q)); mul_b = $signed({2'b0, freq_q}); end
      pfn_pkg::ST_FX1:  begin mul_a = {25'b0, fx_q}; mul_b = {10'b0, fx_q}; end
      pfn_pkg::ST_FX2:  begin mul_a = {25'b0, mul_q[31:16]}; mul_b = {10'b0, fx_q}; end
      pfn_pkg::ST_FX3:  begin mul_a = 41'(fade_lin(fx_q)); mul_b = {10'b0, fx_q}; end
      pfn_pkg::ST_FX4:  begin mul_a = {25'b0, t3_q}; mul_b = 26'(fade_in); end
      pfn_pkg::ST_FY1:  begin mul_a = {25'b0, fy_q}; mul_b = {10'b0, fy_q}; end
      pfn_pkg::ST_FY2:  begin mul_a = {25'b0, mul_q[31:16]}; mul_b = {10'b0, fy_q}; end
      pfn_pkg::ST_FY3:  begin mul_a = 41'(fade_lin(fy_q)); mul_b = {10'b0, fy_q}; end
      pfn_pkg::ST_FY4:  begin mul_a = {25'b0, t3_q}; mul_b = 26'(fade_in); end
      pfn_pkg::ST_D00A: begin mul_a = 41'($signed(g00_q[15:0])); mul_b = {10'b0, fx_q}; end
      pfn_pkg::ST_D00B: begin mul_a = 41'($signed(g00_q[31:16])); mul_b = {10'b0, fy_q}; end
      pfn_pkg::ST_D10A: begin mul_a = 41'($signed(g10_q[15:0])); mul_b = 26'(fxm); end
      pfn_pkg::ST_D10B: begin mul_a = 41'($signed(g10_q[31:16])); mul_b = {10'b0, fy_q}; end
      pfn_pkg::ST_D01A: begin mul_a = 41'($signed(g01_q[15:0])); mul_b = {10'b0, fx_q}; end
      pfn_pkg::ST_D01B: begin mul_a = 41'($signed(g01_q[31:16])); mul_b = 26'(fym); end
      pfn_pkg::ST_D11A: begin mul_a = 41'($signed(g11_q[15:0])); mul_b = 26'(fxm); end
      pfn_pkg::ST_D11B: begin mul_a = 41'($signed(g11_q[31:16])); mul_b = 26'(fym); end
      pfn_pkg::ST_L0:   begin mul_a = 41'(22'(d10_q) - 22'(d00_q)); mul_b = {9'b0, u_q}; end
      pfn_pkg::ST_L1:   begin mul_a = 41'(22'(d11_q) - 22'(d01_q)); mul_b = {9'b0, u_q}; end
      pfn_pkg::ST_L3:   begin mul_a = 41'(23'(l1_q) - 23'(l0_q)); mul_b = {9'b0, v_q}; end
      pfn_pkg::ST_TM:   begin mul_a = 41'(noise_q); mul_b = {2'b0, amp_q}; end
      pfn_pkg::ST_AMP:  begin mul_a = {17'b0, amp_q}; mul_b = {2'b0, persistence_i}; end
      pfn_pkg::ST_FRQ:  begin mul_a = {17'b0, freq_q}; mul_b = {2'b0, lacunarity_i}; end
      pfn_pkg::ST_PMUL: begin mul_a = 41'(acc_q); mul_b = 26'(quot_q); end
      pfn_pkg::ST_SMUL: begin mul_a = 41'(acc_q); mul_b = {2'b0, noise_scale_i}; end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    mul_q <= mul_a * mul_b;
  end

  // Step captures
  always_ff @(posedge clk_i) begin
    if (in_fire_i && (cmd_i.step == pfn_pkg::ST_IDLE)
        && (in_kind_i == pfn_pkg::KIND_EVAL)) begin
      cx_q    <= coord_x_i;
      cy_q    <= coord_y_i;
      freq_q  <= base_freq_i;
      amp_q   <= base_amp_i;
      total_q <= '0;
      asum_q  <= '0;
      sat_q   <= 1'b0;
    end
    case (cmd_i.step)
      pfn_pkg::ST_SY:   begin x0_q <= mul_q[39:32]; fx_q <= mul_q[31:16]; end
      pfn_pkg::ST_FX1:  begin y0_q <= mul_q[39:32]; fy_q <= mul_q[31:16]; end
      pfn_pkg::ST_FX2:  px0_q <= perm_rd;
      pfn_pkg::ST_FX3:  begin t3_q <= mul_q[31:16]; px1_q <= perm_rd; end
      pfn_pkg::ST_FX4:  h00_q <= perm_rd;
      pfn_pkg::ST_FY1:  begin u_q <= p16[16:0]; h10_q <= perm_rd; end
      pfn_pkg::ST_FY2:  h01_q <= perm_rd;
      pfn_pkg::ST_FY3:  begin t3_q <= mul_q[31:16]; h11_q <= perm_rd; end
      pfn_pkg::ST_FY4:  g00_q <= grad_rd;
      pfn_pkg::ST_D00A: begin v_q <= p16[16:0]; g10_q <= grad_rd; end
      pfn_pkg::ST_D00B: begin dacc_q <= mul_q[33:0]; g01_q <= grad_rd; end
      pfn_pkg::ST_D10A: begin d00_q <= dot_new; g11_q <= grad_rd; end
      pfn_pkg::ST_D10B: dacc_q <= mul_q[33:0];
      pfn_pkg::ST_D01A: d10_q <= dot_new;
      pfn_pkg::ST_D01B: dacc_q <= mul_q[33:0];
      pfn_pkg::ST_D11A: d01_q <= dot_new;
      pfn_pkg::ST_D11B: dacc_q <= mul_q[33:0];
      pfn_pkg::ST_L0:   d11_q <= dot_new;
      pfn_pkg::ST_L1:   l0_q <= 22'(d00_q) + p16[21:0];
      pfn_pkg::ST_L2:   l1_q <= 22'(d01_q) + p16[21:0];
      pfn_pkg::ST_N:    noise_q <= l0_q + p16[21:0];
      pfn_pkg::ST_AMP: begin
        total_q <= total_q + p16[TOT_W-1:0];
        asum_q  <= asum_q + AS_W'(amp_q);
      end
      pfn_pkg::ST_FRQ:  amp_q <= sat24(p16);
      pfn_pkg::ST_NXT:  freq_q <= sat24(p16);
      // Restoring division of |total| << 16 by the amplitude sum
      pfn_pkg::ST_DINIT: begin
        num_q <= {tot_abs, 16'b0};
        rem_q <= '0;
        neg_q <= total_q[TOT_W-1];
      end
      pfn_pkg::ST_DIV: begin
        num_q <= {num_q[DIV_W-2:0], rem_ge};
        rem_q <= rem_ge ? AS_W'(rem_sh - {1'b0, asum_q}) : rem_sh[AS_W-1:0];
      end
      // Clamp the quotient to +-4.0, start the power at 1.0
      pfn_pkg::ST_DEND: begin
        acc_q <= 40'sd65536;
        if (quot_mag > DIV_W'(pfn_pkg::QUOT_LIM)) begin
          quot_q <= neg_q ? -20'sd262144 : 20'sd262144;
          sat_q  <= 1'b1;
        end else begin
          quot_q <= neg_q ? -$signed(quot_mag[19:0]) : $signed(quot_mag[19:0]);
        end
      end
      pfn_pkg::ST_PCAP: begin
        if (p16 > POW_HI) begin
          acc_q <= POW_HI[39:0];
          sat_q <= 1'b1;
        end else if (p16 < POW_LO) begin
          acc_q <= POW_LO[39:0];
          sat_q <= 1'b1;
        end else begin
          acc_q <= p16[39:0];
        end
      end
      pfn_pkg::ST_SCAP: begin
        if (p16 > I32_HI) begin
          res_q <= I32_HI[31:0];
          sat_q <= 1'b1;
        end else if (p16 < I32_LO) begin
          res_q <= I32_LO[31:0];
          sat_q <= 1'b1;
        end else begin
          res_q <= p16[31:0];
        end
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_value_q <= cmd_i.err ? 32'd0 : res_q;
      out_sat_q   <= cmd_i.err ? 1'b0 : sat_q;
      out_err_q   <= cmd_i.err;
    end
  end

  assign noise_value_o = out_value_q;
  assign saturated_o   = out_sat_q;
  assign error_o       = out_err_q;

endmodule

`default_nettype wire

>>> rtl/core/perlin_fbm_noise_2d_unit.sv
// ============================================================================
// perlin_fbm_noise_2d_unit: 2D Perlin gradient noise with fBm octave sum
// Top level: configuration registers, sequencer and datapath.
// ============================================================================
// Usage:
//   s_axis carries one item per transfer. tuser is the item kind: load a
//   permutation entry, load a gradient entry, or evaluate a point. Loads give
//   no result. An evaluate gives one result on m_axis:
//   tdata is the signed Q15.16 noise value, tuser holds the saturated and error flags.
//   Registers are written through cfg_we_i/cfg_idx_i/cfg_data_i; the user must
//   write them only while idle, as the block itself does not enforce it.
//   Each of N octaves (after clamping to MAX_OCTAVES) walks 27 steps of one
//   shared signed multiplier and the single read ports of the two tables;
//   the quotient comes from a restoring divider of DIV_W bits (51 for 16
//   octaves) that retires one bit per cycle; zero octaves skip to an error result.
// s_axis_tready is high only while no evaluate is in progress; items run one
// at a time. A finished result waits in the output register while the next
// item is accepted; if the receiver stalls, the next result holds in the
// final step until the register frees up.
// Reset clears control state and restores register defaults. The tables are
// not cleared and must be loaded before use.
// ============================================================================
`default_nettype none

module perlin_fbm_noise_2d_unit #(
  parameter int MAX_OCTAVES = pfn_pkg::DEFAULT_MAX_OCTAVES
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // Input stream
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [111:0] s_axis_tdata,  // table_index, perm_value, grad_x,
                                            // grad_y, coord_x, coord_y
  input  wire logic [1:0]   s_axis_tuser,  // kind
  // Result stream
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [31:0]       m_axis_tdata,  // noise_value
  output logic [1:0]        m_axis_tuser,  // saturated, error
  // Configuration
  input  wire logic         cfg_we_i,
  input  wire logic [2:0]   cfg_idx_i,
  input  wire logic [23:0]  cfg_data_i
);

  localparam int CNT_W = $clog2(MAX_OCTAVES + 1);
  localparam int AS_W  = 24 + CNT_W;
  localparam int TOT_W = 30 + CNT_W;
  localparam int DIV_W = TOT_W + 16;

  logic [23:0] base_freq_q, lacunarity_q, persistence_q, base_amp_q, noise_scale_q;
  logic [4:0]  oct_count_q;
  logic [3:0]  contrast_q;
  logic [CNT_W-1:0] eff_count;
  logic        in_fire;
  logic        saturated, error_flag;
  pfn_pkg::kind_e   in_kind;
  pfn_pkg::cmd_t    cmd;
  pfn_pkg::status_t status;

  assign in_kind = pfn_pkg::kind_e'(s_axis_tuser);
  assign in_fire = s_axis_tvalid && s_axis_tready;

  // Octave count above the limit counts as the limit
  assign eff_count = ({1'b0, oct_count_q} > 6'(MAX_OCTAVES)) ? CNT_W'(MAX_OCTAVES)
                                                              : CNT_W'(oct_count_q);

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_freq_q   <= pfn_pkg::RST_BASE_FREQ;
      lacunarity_q  <= pfn_pkg::RST_LACUNARITY;
      persistence_q <= pfn_pkg::RST_PERSISTENCE;
      base_amp_q    <= pfn_pkg::RST_BASE_AMP;
      oct_count_q   <= pfn_pkg::RST_OCT_COUNT;
      contrast_q    <= pfn_pkg::RST_CONTRAST;
      noise_scale_q <= pfn_pkg::RST_NOISE_SCALE;
    end else if (cfg_we_i) begin
      unique case (pfn_pkg::reg_e'(cfg_idx_i))
        pfn_pkg::REG_BASE_FREQ:   base_freq_q   <= cfg_data_i;
        pfn_pkg::REG_LACUNARITY:  lacunarity_q  <= cfg_data_i;
        pfn_pkg::REG_PERSISTENCE: persistence_q <= cfg_data_i;
        pfn_pkg::REG_BASE_AMP:    base_amp_q    <= cfg_data_i;
        pfn_pkg::REG_OCT_COUNT:   oct_count_q   <= cfg_data_i[4:0];
        pfn_pkg::REG_CONTRAST:    contrast_q    <= cfg_data_i[3:0];
        pfn_pkg::REG_NOISE_SCALE: noise_scale_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  pfn_ctrl #(.CNT_W(CNT_W), .DIV_W(DIV_W)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_kind_i   (in_kind),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .eff_count_i (eff_count),
    .contrast_i  (contrast_q),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  pfn_dp #(.AS_W(AS_W), .TOT_W(TOT_W), .DIV_W(DIV_W)) u_dp (
    .clk_i         (clk_i),
    .in_fire_i     (in_fire),
    .in_kind_i     (in_kind),
    .table_index_i (s_axis_tdata[7:0]),
    .perm_value_i  (s_axis_tdata[15:8]),
    .grad_x_i      (s_axis_tdata[31:16]),
    .grad_y_i      (s_axis_tdata[47:32]),
    .coord_x_i     (s_axis_tdata[79:48]),
    .coord_y_i     (s_axis_tdata[111:80]),
    .base_freq_i   (base_freq_q),
    .lacunarity_i  (lacunarity_q),
    .persistence_i (persistence_q),
    .base_amp_i    (base_amp_q),
    .noise_scale_i (noise_scale_q),
    .cmd_i         (cmd),
    .status_o      (status),
    .noise_value_o (m_axis_tdata),
    .saturated_o   (saturated),
    .error_o       (error_flag)
  );

  assign m_axis_tuser = {error_flag, saturated};

  // An accepted evaluate closes the input until its result is done
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (in_kind == pfn_pkg::KIND_EVAL)) |=> !s_axis_tready)
    else $error("input still open after evaluate item");

  // Error results carry a zero value and no saturation flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[1]) |-> (m_axis_tdata == 32'd0 && !m_axis_tuser[0]))
    else $error("error result with nonzero payload");

  // A table load never produces a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !m_axis_tvalid
     && (in_kind == pfn_pkg::KIND_PERM || in_kind == pfn_pkg::KIND_GRAD))
    |=> !m_axis_tvalid)
    else $error("result raised by table load");

endmodule

`default_nettype wire
